// File: rtl/core/qit_pkg.sv
// Package for quad_index_table: table sizes, derived widths and command/status codes.
// No dependencies. Used by rtl/core/quad_index_table.sv.
`default_nettype none

package qit_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ATOM_BITS   = 16;

  // Derived widths
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 4 * ATOM_BITS;

  // Port field widths
  localparam int ATOM_PORT_W = 16;
  localparam int SLOT_W      = 8;
  localparam int USED_W      = 9;

  typedef logic [ATOM_BITS-1:0] atom_t;
  typedef logic [ENTRY_W-1:0]   entry_t;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/quad_index_table.sv
// Top level of quad_index_table: sequencer, scan compare unit and entry memory.
// Depends on qit_pkg (rtl/core/qit_pkg.sv).
//
// Operation: S_SCAN reads the stored entries in slot order and compares each
// registered read with the query, forward or reversed, up to the first match
// or the last stored entry. A delete that frees a slot other than the last
// moves the last entry into it (S_MOVE_RD, S_MOVE_WR); S_DONE then waits for a
// free output register. One command at a time: commands are taken only in S_IDLE.
// Reset: synchronous; clears the state, the entry count and out_valid. The
// entry memory is not cleared: only slots below the count are ever compared.
`default_nettype none

module quad_index_table
  import qit_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Command channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             command,
  input  wire logic [ATOM_PORT_W-1:0] atom_a,
  input  wire logic [ATOM_PORT_W-1:0] atom_b,
  input  wire logic [ATOM_PORT_W-1:0] atom_c,
  input  wire logic [ATOM_PORT_W-1:0] atom_d,
  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  status,
  output logic [SLOT_W-1:0]           slot,
  output logic [USED_W-1:0]           entries_used
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DONE
  } state_t;

  state_t           state;
  logic [1:0]       cmd;
  atom_t            q_a, q_b, q_c, q_d;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] issue_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] move_src;
  status_t          res_status;
  logic [IDX_W-1:0] res_slot;

  // Entry memory
  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  // Scan compare unit
  logic             fwd_match, rev_match, match;
  logic             scan_done, scan_hit;
  logic             full;
  logic [CNT_W-1:0] last_cnt;
  logic [31:0]      slot_ext, used_ext;

  assign in_ready  = (state == S_IDLE);
  assign fwd_match = (rd_data == {q_a, q_b, q_c, q_d});
  assign rev_match = (rd_data == {q_d, q_c, q_b, q_a});
  assign match     = cmp_valid && (fwd_match || rev_match);
  assign scan_hit  = match;
  assign scan_done = match || (!cmp_valid && (issue_idx >= count));
  assign full      = (count >= CNT_W'(TABLE_DEPTH));
  assign last_cnt  = count - CNT_W'(1);
  assign slot_ext  = 32'(res_slot);
  assign used_ext  = 32'(count);

  // Select memory read address and write port
  always_comb begin
    mem_raddr = issue_idx[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = {q_a, q_b, q_c, q_d};
    if (state == S_MOVE_RD) begin
      mem_raddr = move_src;
    end
    if (state == S_SCAN && scan_done && !scan_hit && cmd == CMD_ADD && !full) begin
      mem_we = 1'b1;
    end
    if (state == S_MOVE_WR) begin
      mem_we    = 1'b1;
      mem_waddr = hit_idx;
      mem_wdata = rd_data;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd       <= command;
            q_a       <= atom_a[ATOM_BITS-1:0];
            q_b       <= atom_b[ATOM_BITS-1:0];
            q_c       <= atom_c[ATOM_BITS-1:0];
            q_d       <= atom_d[ATOM_BITS-1:0];
            issue_idx <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Advance the read pointer; the compare of each entry follows its read in the next cycle
          if (issue_idx < count) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= issue_idx[IDX_W-1:0];
            issue_idx <= issue_idx + CNT_W'(1);
          end else begin
            cmp_valid <= 1'b0;
          end
          if (scan_done) begin
            cmp_valid  <= 1'b0;
            hit_idx    <= cmp_idx;
            res_status <= ST_NOT_FOUND;
            res_slot   <= '0;
            state      <= S_DONE;
            priority case (cmd)
              CMD_FIND: begin
                if (scan_hit) begin
                  res_status <= ST_OK;
                  res_slot   <= cmp_idx;
                end
              end
              CMD_ADD: begin
                if (scan_hit) begin
                  res_status <= ST_EXISTS;
                end else if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  res_slot   <= count[IDX_W-1:0];
                  count      <= count + CNT_W'(1);
                end
              end
              CMD_DELETE: begin
                if (scan_hit) begin
                  res_status <= ST_OK;
                  res_slot   <= cmp_idx;
                  count      <= last_cnt;
                  move_src   <= last_cnt[IDX_W-1:0];
                  if (cmp_idx != last_cnt[IDX_W-1:0]) begin
                    state <= S_MOVE_RD;
                  end
                end
              end
              default: begin
                res_status <= ST_NOT_FOUND;
              end
            endcase
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // Load the result once the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            slot         <= slot_ext[SLOT_W-1:0];
            entries_used <= used_ext[USED_W-1:0];
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for quad_index_table: a shadow copy of the table predicts
// each reply; directed commands, a full-table fill and random phases drive it.
// Depends on qit_pkg (rtl/core/qit_pkg.sv) and rtl/core/quad_index_table.sv.
`default_nettype none

import qit_pkg::*;

typedef struct packed {
  status_t             status;
  logic [SLOT_W-1:0]   slot;
  logic [USED_W-1:0]   used;
} table_reply_t;

// Shadow of the table contents and the replies still owed by the block
class quad_table_shadow;
  entry_t       entry [TABLE_DEPTH];
  int unsigned  used;
  table_reply_t owed_replies [$];
  int           errors;

  function new();
    used   = 0;
    errors = 0;
  endfunction

  // Lowest slot matching q forward or reversed; TABLE_DEPTH when absent
  function int unsigned match_slot(entry_t q);
    atom_t       a, b, c, d;
    entry_t      rev;
    int unsigned i;
    {a, b, c, d} = q;
    rev = {d, c, b, a};
    for (i = 0; i < used && i < TABLE_DEPTH; i++) begin
      if (entry[i] == q || entry[i] == rev) return i;
    end
    return TABLE_DEPTH;
  endfunction

  // Apply one accepted command transaction and queue the reply it owes
  function void note_command(logic [1:0] cmd, logic [ATOM_PORT_W-1:0] a,
                             logic [ATOM_PORT_W-1:0] b, logic [ATOM_PORT_W-1:0] c,
                             logic [ATOM_PORT_W-1:0] d);
    entry_t       q;
    int unsigned  hit;
    int unsigned  slot_no;
    table_reply_t r;
    q = {a[ATOM_BITS-1:0], b[ATOM_BITS-1:0], c[ATOM_BITS-1:0], d[ATOM_BITS-1:0]};
    hit = match_slot(q);
    r.status = ST_NOT_FOUND;
    slot_no = 0;
    case (cmd)
      CMD_FIND: begin
        if (hit < TABLE_DEPTH) begin
          r.status = ST_OK;
          slot_no = hit;
        end
      end
      CMD_ADD: begin
        if (hit < TABLE_DEPTH) begin
          r.status = ST_EXISTS;
        end else if (used >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entry[used] = q;
          slot_no = used;
          used++;
          r.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        // Move the last entry into the freed slot unless it is the one removed
        if (hit < TABLE_DEPTH) begin
          if (hit != used - 1) entry[hit] = entry[used - 1];
          used--;
          r.status = ST_OK;
          slot_no = hit;
        end
      end
      default: ;
    endcase
    r.slot = SLOT_W'(slot_no);
    r.used = USED_W'(used);
    owed_replies.push_back(r);
  endfunction

  task report(string what);
    $display("MISMATCH: %s", what);
    errors++;
  endtask

  // Compare one accepted reply transaction with the oldest owed reply
  task check_reply(logic [1:0] st, logic [SLOT_W-1:0] sl, logic [USED_W-1:0] cnt);
    table_reply_t want;
    if (owed_replies.size() == 0) begin
      report($sformatf("reply with none owed: status=%0d slot=%0d used=%0d", st, sl, cnt));
      return;
    end
    want = owed_replies.pop_front();
    if (st !== want.status)
      report($sformatf("status %0d, expected %0d", st, want.status));
    if (sl !== want.slot)
      report($sformatf("slot %0d, expected %0d", sl, want.slot));
    if (cnt !== want.used)
      report($sformatf("entries_used %0d, expected %0d", cnt, want.used));
  endtask
endclass

module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         DRAIN_CYCLES = TABLE_DEPTH + 40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             command = CMD_FIND;
  logic [ATOM_PORT_W-1:0] atom_a = '0;
  logic [ATOM_PORT_W-1:0] atom_b = '0;
  logic [ATOM_PORT_W-1:0] atom_c = '0;
  logic [ATOM_PORT_W-1:0] atom_d = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [SLOT_W-1:0]      slot;
  logic [USED_W-1:0]      entries_used;

  int unsigned send_idle  = 0;
  int unsigned recv_stall = 0;

  quad_table_shadow sb = new();

  quad_index_table dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .atom_a       (atom_a),
    .atom_b       (atom_b),
    .atom_c       (atom_c),
    .atom_d       (atom_d),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .slot         (slot),
    .entries_used (entries_used)
  );

  always #5 clk = ~clk;

  // Hold the run to a bound well past the slowest correct run
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Accept replies and stall the result channel at random
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_reply(status, slot, entries_used);
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Present one command transaction, with an optional idle gap first
  task automatic send_command(input logic [1:0] cmd, input logic [ATOM_PORT_W-1:0] a,
                              input logic [ATOM_PORT_W-1:0] b,
                              input logic [ATOM_PORT_W-1:0] c,
                              input logic [ATOM_PORT_W-1:0] d);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    atom_a   <= a;
    atom_b   <= b;
    atom_c   <= c;
    atom_d   <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, a, b, c, d);
  endtask

  function automatic atom_t extreme_atom();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return atom_t'($urandom);
    endcase
  endfunction

  initial begin
    int          ph, seg, n, target, r, pick;
    logic [1:0]  cmd;
    atom_t       qa, qb, qc, qd;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused code, reversed match, moves, last-entry delete
    send_command(CMD_FIND,   16'd1, 16'd2, 16'd3, 16'd4);
    send_command(CMD_DELETE, 16'd1, 16'd2, 16'd3, 16'd4);
    send_command(CMD_UNUSED, 16'd0, 16'd0, 16'd0, 16'd0);
    send_command(CMD_ADD,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(CMD_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(CMD_ADD,    16'd1, 16'd2, 16'd3, 16'd4);
    send_command(CMD_ADD,    16'd4, 16'd3, 16'd2, 16'd1);
    send_command(CMD_ADD,    16'd1, 16'd2, 16'd3, 16'd4);
    send_command(CMD_FIND,   16'd4, 16'd3, 16'd2, 16'd1);
    send_command(CMD_FIND,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(CMD_FIND,   16'd1, 16'd2, 16'd3, 16'd5);
    send_command(CMD_FIND,   16'd1, 16'd2, 16'd4, 16'd3);
    send_command(CMD_ADD,    16'd5, 16'd6, 16'd6, 16'd5);
    send_command(CMD_FIND,   16'd5, 16'd6, 16'd6, 16'd5);
    send_command(CMD_UNUSED, 16'd1, 16'd2, 16'd3, 16'd4);
    send_command(CMD_DELETE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(CMD_FIND,   16'd5, 16'd6, 16'd6, 16'd5);
    send_command(CMD_DELETE, 16'd4, 16'd3, 16'd2, 16'd1);
    send_command(CMD_DELETE, 16'd1, 16'd2, 16'd3, 16'd4);
    send_command(CMD_ADD,    16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000);
    send_command(CMD_DELETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(CMD_FIND,   16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000);
    send_command(CMD_DELETE, 16'd5, 16'd6, 16'd6, 16'd5);
    send_command(CMD_DELETE, 16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5);

    // Fill the table, then hit the full and already-exists cases
    while (sb.used < TABLE_DEPTH)
      send_command(CMD_ADD, ATOM_PORT_W'($urandom), ATOM_PORT_W'($urandom),
                   ATOM_PORT_W'($urandom), ATOM_PORT_W'($urandom));
    {qa, qb, qc, qd} = sb.entry[7];
    send_command(CMD_ADD, qd, qc, qb, qa);
    send_command(CMD_ADD, ATOM_PORT_W'($urandom), ATOM_PORT_W'($urandom),
                 ATOM_PORT_W'($urandom), ATOM_PORT_W'($urandom));
    {qa, qb, qc, qd} = sb.entry[TABLE_DEPTH-1];
    send_command(CMD_FIND, qa, qb, qc, qd);

    // Random phases: no idling, sender idle, receiver stalling, both lightly
    for (ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 88 : (ph == 3) ? 10 : 0;
      recv_stall = (ph == 2) ? 88 : (ph == 3) ? 10 : 0;
      for (seg = 0; seg < ((ph == 0) ? 2 : 4); seg++) begin
        // Steer the fill level toward a target for this segment
        case ($urandom_range(0, 3))
          0:       target = 0;
          1:       target = $urandom_range(1, 16);
          2:       target = $urandom_range(0, TABLE_DEPTH);
          default: target = TABLE_DEPTH;
        endcase
        if (ph == 0) target = TABLE_DEPTH;
        for (n = 0; n < ((ph == 0) ? 50 : 70); n++) begin
          r = $urandom_range(0, 99);
          if (sb.used < target)
            cmd = (r < 60) ? CMD_ADD : (r < 80) ? CMD_FIND : (r < 95) ? CMD_DELETE : CMD_UNUSED;
          else
            cmd = (r < 15) ? CMD_ADD : (r < 35) ? CMD_FIND : (r < 95) ? CMD_DELETE : CMD_UNUSED;
          pick = $urandom_range(0, 9);
          if (cmd == CMD_ADD && $urandom_range(0, 3) != 0) pick = 9;
          if (cmd == CMD_DELETE && $urandom_range(0, 3) != 0) pick = 0;
          if (sb.used == 0 && pick <= 5) pick = 9;
          if (pick <= 5) begin
            // Stored quadruple, either order, sometimes off by one bit
            {qa, qb, qc, qd} = sb.entry[$urandom_range(0, sb.used - 1)];
            if ($urandom_range(0, 1)) {qa, qb, qc, qd} = {qd, qc, qb, qa};
            if (pick == 5) begin
              case ($urandom_range(0, 3))
                0:       qa ^= atom_t'(1) << $urandom_range(0, ATOM_BITS - 1);
                1:       qb ^= atom_t'(1) << $urandom_range(0, ATOM_BITS - 1);
                2:       qc ^= atom_t'(1) << $urandom_range(0, ATOM_BITS - 1);
                default: qd ^= atom_t'(1) << $urandom_range(0, ATOM_BITS - 1);
              endcase
            end
          end else if (pick == 6) begin
            qa = atom_t'($urandom_range(0, 3));
            qb = atom_t'($urandom_range(0, 3));
            qc = atom_t'($urandom_range(0, 3));
            qd = atom_t'($urandom_range(0, 3));
          end else if (pick == 7) begin
            qa = extreme_atom();
            qb = extreme_atom();
            qc = extreme_atom();
            qd = extreme_atom();
          end else begin
            qa = atom_t'($urandom);
            qb = atom_t'($urandom);
            qc = atom_t'($urandom);
            qd = atom_t'($urandom);
          end
          send_command(cmd, qa, qb, qc, qd);
        end
      end
    end

    // Drop valid, drain owed replies, then allow one more scan time
    in_valid   <= 1'b0;
    send_idle  = 0;
    recv_stall = 0;
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/qit_pkg.sv
rtl/core/quad_index_table.sv
bench/tb_top.sv
